// File: hdl/hsir_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsir_pkg
// Shared types, constants and CRC helper for the humidity sensor responder.
// ----------------------------------------------------------------------------
package hsir_pkg;

   // Bus event codes
   typedef enum logic [1:0] {
      OP_WR_START = 2'd0,
      OP_RD_START = 2'd1,
      OP_WR_BYTE  = 2'd2,
      OP_RD_BYTE  = 2'd3
   } op_type;

   localparam int unsigned PKT_BYTES = 6;
   localparam int unsigned POS_W     = $clog2(PKT_BYTES + 1);

   // Sensor ranges in hundredths
   localparam logic signed [15:0] T_MIN_C    = -16'sd4000;
   localparam logic signed [15:0] T_MAX_C    = 16'sd12500;
   localparam logic signed [15:0] T_OFFSET_C = 16'sd4500;
   localparam logic signed [15:0] H_MIN_C    = 16'sd0;
   localparam logic signed [15:0] H_MAX_C    = 16'sd10000;

   // Reciprocal constants: raw_t = (tt * 13107) / 3500, raw_h = (h * 13107) / 2000,
   // each done as one multiply by ceil(13107 * 2^k / d) and a right shift by k.
   localparam int unsigned T_SHIFT = 26;
   localparam int unsigned H_SHIFT = 25;
   localparam logic [27:0] T_RECIP = 28'd251313109;
   localparam logic [27:0] H_RECIP = 28'd219898971;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] FILLER   = 8'hFF;

   typedef logic [7:0] byte_type;
   typedef byte_type [PKT_BYTES-1:0] pkt_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       from_packet;
   } rsp_type;

   // One byte through the CRC-8, MSB first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                            input logic [7:0] data);
      logic [7:0] crc;
      crc = crc_in ^ data;
      for (int k = 0; k < 8; k++) begin
         if (crc[7]) begin
            crc = {crc[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[6:0], 1'b0};
         end
      end
      return crc;
   endfunction

endpackage
`default_nettype wire

// File: hdl/hsir_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsir_req_if / hsir_rsp_if
// Valid/ready channels for bus events and read-byte results.
// ----------------------------------------------------------------------------
interface hsir_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  write_byte;
   logic signed [15:0] temperature_centi;
   logic signed [15:0] humidity_centi;

   modport source (output valid, output opcode, output write_byte,
                   output temperature_centi, output humidity_centi, input ready);
   modport sink   (input valid, input opcode, input write_byte,
                   input temperature_centi, input humidity_centi, output ready);
   modport monitor (input valid, input ready, input opcode, input write_byte,
                    input temperature_centi, input humidity_centi);
endinterface

interface hsir_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       from_packet;

   modport source  (output valid, output read_data, output from_packet, input ready);
   modport sink    (input valid, input read_data, input from_packet, output ready);
   modport monitor (input valid, input ready, input read_data, input from_packet);
endinterface
`default_nettype wire

// File: hdl/hsir_pkt_build.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsir_pkt_build
// Clamp, scale and CRC the sensor values into the six-byte packet.
// ----------------------------------------------------------------------------
module hsir_pkt_build (
   input  wire logic signed [15:0] temperature_centi,
   input  wire logic signed [15:0] humidity_centi,
   output hsir_pkg::pkt_type       pkt
);
   import hsir_pkg::*;

   logic signed [15:0] t_cl;
   logic signed [15:0] h_cl;
   logic signed [15:0] t_off;
   logic [14:0]        t_idx;
   logic [13:0]        h_idx;
   logic [42:0]        t_prod;
   logic [41:0]        h_prod;
   logic [15:0]        raw_t;
   logic [15:0]        raw_h;

   always_comb begin
      t_cl = temperature_centi;
      if (temperature_centi < T_MIN_C) begin
         t_cl = T_MIN_C;
      end else if (temperature_centi > T_MAX_C) begin
         t_cl = T_MAX_C;
      end
      h_cl = humidity_centi;
      if (humidity_centi < H_MIN_C) begin
         h_cl = H_MIN_C;
      end else if (humidity_centi > H_MAX_C) begin
         h_cl = H_MAX_C;
      end
   end

   // Offset range is 500..17000, clamped humidity 0..10000
   assign t_off = t_cl + T_OFFSET_C;
   assign t_idx = t_off[14:0];
   assign h_idx = h_cl[13:0];

   assign t_prod = 43'(t_idx) * 43'(T_RECIP);
   assign h_prod = 42'(h_idx) * 42'(H_RECIP);
   assign raw_t  = t_prod[T_SHIFT +: 16];
   assign raw_h  = h_prod[H_SHIFT +: 16];

   always_comb begin
      pkt[0] = raw_t[15:8];
      pkt[1] = raw_t[7:0];
      pkt[2] = crc8_byte(crc8_byte(CRC_INIT, raw_t[15:8]), raw_t[7:0]);
      pkt[3] = raw_h[15:8];
      pkt[4] = raw_h[7:0];
      pkt[5] = crc8_byte(crc8_byte(CRC_INIT, raw_h[15:8]), raw_h[7:0]);
   end

endmodule
`default_nettype wire

// File: hdl/hsir_rsp_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsir_rsp_reg
// Result register: holds one read-byte result until the sink takes it.
// ----------------------------------------------------------------------------
module hsir_rsp_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire hsir_pkg::rsp_type rsp_in,
   output logic                   free,
   hsir_rsp_if.source             rsp_ch
);
   import hsir_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // Free when empty or emptied by a transfer this cycle
   assign free     = !valid_ff || rsp_ch.ready;
   assign valid_in = load || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.read_data   = data_ff.read_data;
   assign rsp_ch.from_packet = data_ff.from_packet;

endmodule
`default_nettype wire

// File: hdl/humidity_sensor_i2c_responder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_sensor_i2c_responder_core
// Transaction-level responder for a temperature/humidity sensor on a two-wire bus.
// ----------------------------------------------------------------------------
// One bus event is taken per transfer on req_ch, and a new event can be taken in
// every clock. Each event passes through an input register and is resolved from
// it against the responder state; only a read-byte event produces a result, which
// goes from the input register into the result register and is offered on rsp_ch
// from there. The sustained rate is one event per clock; it drops only while a
// read-byte event waits behind a full, stalled result register. Write-start
// clears the written-byte count; the second and any later written byte of a
// write, or a read start before any packet exists, builds the six-byte packet
// (temperature pair, CRC-8, humidity pair, CRC-8) from the sensor values carried
// by that event. Read bytes walk the packet and then return the filler 0xFF with
// from_packet low. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module humidity_sensor_i2c_responder_core (
   input  wire logic  clock,
   input  wire logic  reset,
   hsir_req_if.sink   req_ch,
   hsir_rsp_if.source rsp_ch
);
   import hsir_pkg::*;

   // Input register
   logic               s1_valid_ff;
   logic               s1_valid_in;
   op_type             s1_op_ff;
   logic signed [15:0] s1_temp_ff;
   logic signed [15:0] s1_hum_ff;

   // Responder state
   pkt_type            pkt_store_ff;
   logic               pkt_valid_ff;
   logic               pkt_valid_in;
   logic [POS_W-1:0]   rd_pos_ff;
   logic [POS_W-1:0]   rd_pos_in;
   logic [1:0]         wr_cnt_ff;
   logic [1:0]         wr_cnt_in;

   logic               accept;
   logic               s1_is_read;
   logic               s1_adv;
   logic               rsp_free;
   logic               build;
   pkt_type            pkt_new;
   rsp_type            rsp_new;

   hsir_pkt_build u_pkt_build (
      .temperature_centi (s1_temp_ff),
      .humidity_centi    (s1_hum_ff),
      .pkt               (pkt_new)
   );

   hsir_rsp_reg u_rsp_reg (
      .clock  (clock),
      .reset  (reset),
      .load   (s1_adv && s1_is_read),
      .rsp_in (rsp_new),
      .free   (rsp_free),
      .rsp_ch (rsp_ch)
   );

   // Only a read byte needs room in the result register
   assign s1_is_read   = (s1_op_ff == OP_RD_BYTE);
   assign s1_adv       = s1_valid_ff && (!s1_is_read || rsp_free);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign accept       = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = accept || (s1_valid_ff && !s1_adv);

   // Resolve the event in the input register against the state
   always_comb begin
      wr_cnt_in    = wr_cnt_ff;
      rd_pos_in    = rd_pos_ff;
      pkt_valid_in = pkt_valid_ff;
      build        = 1'b0;
      rsp_new.read_data   = FILLER;
      rsp_new.from_packet = 1'b0;

      case (s1_op_ff)
         OP_WR_START: begin
            wr_cnt_in = 2'd0;
         end
         OP_RD_START: begin
            build = !pkt_valid_ff;
         end
         OP_WR_BYTE: begin
            // Saturate at two; every byte from the second on rebuilds
            if (wr_cnt_ff != 2'd2) begin
               wr_cnt_in = wr_cnt_ff + 2'd1;
            end
            build = (wr_cnt_in == 2'd2);
         end
         OP_RD_BYTE: begin
            if (pkt_valid_ff && (rd_pos_ff < POS_W'(PKT_BYTES))) begin
               rsp_new.read_data   = pkt_store_ff[rd_pos_ff];
               rsp_new.from_packet = 1'b1;
               rd_pos_in           = rd_pos_ff + POS_W'(1);
            end
         end
         default: begin
            wr_cnt_in = wr_cnt_ff;
         end
      endcase

      if (build) begin
         pkt_valid_in = 1'b1;
         rd_pos_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         pkt_valid_ff <= 1'b0;
         rd_pos_ff    <= '0;
         wr_cnt_ff    <= 2'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_adv) begin
            pkt_valid_ff <= pkt_valid_in;
            rd_pos_ff    <= rd_pos_in;
            wr_cnt_ff    <= wr_cnt_in;
         end
      end
   end

   // Payload: load the input register on a transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff   <= op_type'(req_ch.opcode);
         s1_temp_ff <= req_ch.temperature_centi;
         s1_hum_ff  <= req_ch.humidity_centi;
      end
   end

   // Packet store: written whole on each build, no reset
   always_ff @(posedge clock) begin
      if (s1_adv && build) begin
         pkt_store_ff <= pkt_new;
      end
   end

endmodule
`default_nettype wire

// File: hdl/hsir_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsir_checker
// Port-level checks on the result channel of the responder.
// ----------------------------------------------------------------------------
module hsir_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_read_data,
   input wire logic       rsp_from_packet
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_read_data) && $stable(rsp_from_packet))
      else $error("stalled result changed");

   // Filler results always carry 0xFF
   a_filler: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_from_packet |-> rsp_read_data == 8'hFF)
      else $error("filler result is not 0xFF");

   // No result is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind humidity_sensor_i2c_responder_core hsir_checker u_hsir_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_read_data   (rsp_ch.read_data),
   .rsp_from_packet (rsp_ch.from_packet)
);
`default_nettype wire
